@@ hdl/dmwb_pkg.sv @@
// ----------------------------------------------------------------------------
// dmwb_pkg
// Geometry constants, microcode word layout and the control program of the
// direct-mapped write-back cache.
// ----------------------------------------------------------------------------
package dmwb_pkg;

  localparam int NUM_LINES      = 8;
  localparam int LINE_BYTES     = 16;
  localparam int MEMORY_BYTES   = 1048576;
  localparam int DATA_W         = 32;
  localparam int ADDR_W         = 20;
  localparam int WORDS_PER_LINE = LINE_BYTES / 4;
  localparam int MEM_WORDS      = MEMORY_BYTES / 4;
  localparam int OFF_W          = $clog2(WORDS_PER_LINE);
  localparam int IDX_W          = $clog2(NUM_LINES);
  localparam int BYTE_W         = $clog2(LINE_BYTES);
  localparam int TAG_W          = ADDR_W - BYTE_W - IDX_W;
  localparam int MEM_AW         = $clog2(MEM_WORDS);
  localparam int LW_AW          = IDX_W + OFF_W;
  localparam int IN_TDATA_W     = ((ADDR_W + DATA_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W    = ((DATA_W + 2 + 7) / 8) * 8;

  typedef logic [3:0] step_t;
  typedef logic [2:0] cond_t;

  localparam step_t S_CLEAR   = 4'd0;
  localparam step_t S_WAIT    = 4'd1;
  localparam step_t S_LOOKUP  = 4'd2;
  localparam step_t S_DECIDE  = 4'd3;
  localparam step_t S_WB_RD   = 4'd4;
  localparam step_t S_WB_WR   = 4'd5;
  localparam step_t S_FILL_RD = 4'd6;
  localparam step_t S_FILL_WR = 4'd7;
  localparam step_t S_TAG_UPD = 4'd8;
  localparam step_t S_ACCESS  = 4'd9;
  localparam step_t S_RESP    = 4'd10;

  localparam cond_t C_NEVER    = 3'd0;
  localparam cond_t C_NO_INPUT = 3'd1;
  localparam cond_t C_CLR_BUSY = 3'd2;
  localparam cond_t C_HIT      = 3'd3;
  localparam cond_t C_CLEAN    = 3'd4;
  localparam cond_t C_CNT_MORE = 3'd5;
  localparam cond_t C_OUT_FREE = 3'd6;

  typedef struct packed {
    logic  in_ready;
    logic  lookup;
    logic  line_rd;
    logic  wb_wr;
    logic  mem_rd;
    logic  fill_wr;
    logic  cnt_inc;
    logic  tag_upd;
    logic  access;
    logic  resp;
    logic  mem_clear;
    logic  hold;
    cond_t cond;
    step_t target;
  } ucode_t;

  function automatic ucode_t ucode_rom(input step_t step);
    ucode_t u;
    u = '0;
    u.cond   = C_NEVER;
    u.target = S_CLEAR;
    case (step)
      S_CLEAR: begin
        u.mem_clear = 1'b1;
        u.cond      = C_CLR_BUSY;
        u.target    = S_CLEAR;
      end
      S_WAIT: begin
        u.in_ready = 1'b1;
        u.cond     = C_NO_INPUT;
        u.target   = S_WAIT;
      end
      S_LOOKUP: begin
        u.lookup = 1'b1;
        u.cond   = C_HIT;
        u.target = S_ACCESS;
      end
      S_DECIDE: begin
        u.cond   = C_CLEAN;
        u.target = S_FILL_RD;
      end
      S_WB_RD: begin
        u.line_rd = 1'b1;
      end
      S_WB_WR: begin
        u.wb_wr   = 1'b1;
        u.cnt_inc = 1'b1;
        u.cond    = C_CNT_MORE;
        u.target  = S_WB_RD;
      end
      S_FILL_RD: begin
        u.mem_rd = 1'b1;
      end
      S_FILL_WR: begin
        u.fill_wr = 1'b1;
        u.cnt_inc = 1'b1;
        u.cond    = C_CNT_MORE;
        u.target  = S_FILL_RD;
      end
      S_TAG_UPD: begin
        u.tag_upd = 1'b1;
      end
      S_ACCESS: begin
        u.access = 1'b1;
      end
      S_RESP: begin
        u.resp   = 1'b1;
        u.hold   = 1'b1;
        u.cond   = C_OUT_FREE;
        u.target = S_WAIT;
      end
      default: begin
        u.cond   = C_NEVER;
        u.target = S_CLEAR;
      end
    endcase
    return u;
  endfunction

endpackage

@@ hdl/direct_mapped_write_back_cache.sv @@
// ----------------------------------------------------------------------------
// direct_mapped_write_back_cache
// Direct-mapped, write-back, write-allocate cache of 8 lines of four words,
// with its backing memory, run by a microcoded sequencer.
// A hit reads or writes the word in its line; a clean miss first fills the
// line from the backing memory, and a dirty miss first writes the old line
// back, both word by word in the line transfer loops of the sequencer.
// After reset the block clears the backing memory, one word a cycle, before it
// takes the first word.
// ----------------------------------------------------------------------------
module direct_mapped_write_back_cache
  import dmwb_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // byte_address, write_word, zero fill
  input  logic                   in_tuser,   // op
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // read_word, was_hit, did_write_back, zero fill
);

  step_t                step_r;
  step_t                step_nxt;
  ucode_t               ctl;
  logic                 jump;
  logic                 out_free;
  logic                 hit;
  logic                 in_accept;

  logic [MEM_AW-1:0]    clr_cnt_r;
  logic [OFF_W-1:0]     cnt_r;

  logic                 op_r;
  logic [ADDR_W-1:0]    addr_r;
  logic [DATA_W-1:0]    wdata_r;
  logic [OFF_W-1:0]     woff;
  logic [IDX_W-1:0]     idx;
  logic [TAG_W-1:0]     tag;

  logic [NUM_LINES-1:0] line_valid_r;
  logic [NUM_LINES-1:0] line_dirty_r;
  logic [TAG_W-1:0]     line_tag_r [NUM_LINES];
  logic [TAG_W-1:0]     vtag_r;
  logic                 hit_r;
  logic                 wb_r;

  logic [DATA_W-1:0]    lw_mem [NUM_LINES*WORDS_PER_LINE];
  logic [DATA_W-1:0]    lw_q_r;
  logic                 lw_we;
  logic [LW_AW-1:0]     lw_waddr;
  logic [DATA_W-1:0]    lw_wdata;
  logic                 lw_re;
  logic [LW_AW-1:0]     lw_raddr;

  logic [DATA_W-1:0]    bm_mem [MEM_WORDS];
  logic [DATA_W-1:0]    bm_q_r;
  logic                 bm_we;
  logic [MEM_AW-1:0]    bm_waddr;
  logic [DATA_W-1:0]    bm_wdata;

  logic                 out_tvalid_r;
  logic [DATA_W-1:0]    out_word_r;
  logic                 out_hit_r;
  logic                 out_wb_r;

  assign ctl       = ucode_rom(step_r);
  assign in_tready = ctl.in_ready;
  assign in_accept = in_tvalid && in_tready;
  assign out_free  = !out_tvalid_r || out_tready;

  assign woff = addr_r[BYTE_W-1:2];
  assign idx  = addr_r[BYTE_W+IDX_W-1:BYTE_W];
  assign tag  = addr_r[ADDR_W-1:BYTE_W+IDX_W];
  assign hit  = line_valid_r[idx] && (line_tag_r[idx] == tag);

  always_comb begin
    case (ctl.cond)
      C_NEVER:    jump = 1'b0;
      C_NO_INPUT: jump = !in_tvalid;
      C_CLR_BUSY: jump = (clr_cnt_r != {MEM_AW{1'b1}});
      C_HIT:      jump = hit;
      C_CLEAN:    jump = !wb_r;
      C_CNT_MORE: jump = (cnt_r != {OFF_W{1'b1}});
      C_OUT_FREE: jump = out_free;
      default:    jump = 1'b0;
    endcase
    if (jump) begin
      step_nxt = ctl.target;
    end else if (ctl.hold) begin
      step_nxt = step_r;
    end else begin
      step_nxt = step_r + step_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r       <= S_CLEAR;
      clr_cnt_r    <= '0;
      cnt_r        <= '0;
      line_valid_r <= '0;
      line_dirty_r <= '0;
      out_tvalid_r <= 1'b0;
      for (int i = 0; i < NUM_LINES; i++) begin
        line_tag_r[i] <= '0;
      end
    end else begin
      step_r <= step_nxt;
      if (ctl.mem_clear) begin
        clr_cnt_r <= clr_cnt_r + MEM_AW'(1);
      end
      if (ctl.cnt_inc) begin
        cnt_r <= cnt_r + OFF_W'(1);
      end
      if (ctl.tag_upd) begin
        line_valid_r[idx] <= 1'b1;
        line_dirty_r[idx] <= 1'b0;
        line_tag_r[idx]   <= tag;
      end
      if (ctl.access && op_r) begin
        line_dirty_r[idx] <= 1'b1;
      end
      if (ctl.resp && out_free) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_r    <= in_tuser;
      addr_r  <= in_tdata[ADDR_W-1:0];
      wdata_r <= in_tdata[ADDR_W+DATA_W-1:ADDR_W];
    end
    if (ctl.lookup) begin
      hit_r  <= hit;
      wb_r   <= !hit && line_valid_r[idx] && line_dirty_r[idx];
      vtag_r <= line_tag_r[idx];
    end
    if (ctl.resp && out_free) begin
      out_word_r <= op_r ? '0 : lw_q_r;
      out_hit_r  <= hit_r;
      out_wb_r   <= wb_r;
    end
  end

  assign lw_we    = ctl.fill_wr || (ctl.access && op_r);
  assign lw_waddr = ctl.fill_wr ? {idx, cnt_r} : {idx, woff};
  assign lw_wdata = ctl.fill_wr ? bm_q_r : wdata_r;
  assign lw_re    = ctl.line_rd || (ctl.access && !op_r);
  assign lw_raddr = ctl.line_rd ? {idx, cnt_r} : {idx, woff};

  always_ff @(posedge clk) begin
    if (lw_we) begin
      lw_mem[lw_waddr] <= lw_wdata;
    end
    if (lw_re) begin
      lw_q_r <= lw_mem[lw_raddr];
    end
  end

  assign bm_we    = ctl.mem_clear || ctl.wb_wr;
  assign bm_waddr = ctl.mem_clear ? clr_cnt_r : {vtag_r, idx, cnt_r};
  assign bm_wdata = ctl.mem_clear ? '0 : lw_q_r;

  always_ff @(posedge clk) begin
    if (bm_we) begin
      bm_mem[bm_waddr] <= bm_wdata;
    end
    if (ctl.mem_rd) begin
      bm_q_r <= bm_mem[{tag, idx, cnt_r}];
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(OUT_TDATA_W-DATA_W-2){1'b0}}, out_wb_r, out_hit_r, out_word_r};

  a_accept_to_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> step_r == S_LOOKUP)
    else $error("accepted word did not start a lookup");

  a_no_wb_on_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[DATA_W] && out_tdata[DATA_W+1]))
    else $error("write-back reported on a hit");

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    step_r == S_CLEAR |-> !in_tready)
    else $error("word taken while memory clear runs");

  a_line_installed: assert property (@(posedge clk) disable iff (!rst_n)
    step_r == S_TAG_UPD |=> line_valid_r[idx] && line_tag_r[idx] == tag)
    else $error("filled line not installed");

endmodule
